/* rtl/qdr_pkg.sv */
// Package: widths, lookup tables and helper functions for quadrant density redistribution.
`default_nettype none
package qdr_pkg;

  localparam int COORD_W = 13;
  localparam int CNT_W   = 24;
  localparam int AREA_W  = 26;
  localparam int NUM_W   = 26;
  localparam int DEN_W   = 28;
  localparam int RSUM_W  = 28;
  localparam int PROD_W  = RSUM_W + CNT_W;
  localparam int DIFF_W  = PROD_W + 1;
  localparam int OUT_W   = 32;
  localparam int N_QUAD  = 4;
  localparam int N_CELL  = 9;
  localparam int N_LANE  = 9;
  localparam int LANE_W  = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [COORD_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [COORD_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  localparam logic [NUM_W-1:0] ZERO_DIV_RATIO = NUM_W'(2 << 10);

  localparam logic [3:0] CELL_OF [4][4][4] = '{
    '{'{0,1,3,4}, '{2,5,0,0}, '{6,7,0,0}, '{8,0,0,0}},
    '{'{0,3,0,0}, '{1,2,4,5}, '{6,0,0,0}, '{7,8,0,0}},
    '{'{0,1,0,0}, '{2,0,0,0}, '{3,4,6,7}, '{5,8,0,0}},
    '{'{0,0,0,0}, '{1,2,0,0}, '{3,6,0,0}, '{4,5,7,8}}
  };
  localparam logic [3:0] BG_CELL [4][4][4] = '{
    '{'{0,0,0,0}, '{1,2,0,0}, '{3,6,0,0}, '{4,5,7,8}},
    '{'{0,1,0,0}, '{2,0,0,0}, '{3,4,6,7}, '{5,8,0,0}},
    '{'{0,3,0,0}, '{1,2,4,5}, '{6,0,0,0}, '{7,8,0,0}},
    '{'{0,1,3,4}, '{2,5,0,0}, '{6,7,0,0}, '{8,0,0,0}}
  };
  localparam logic [1:0] BG_QUAD [4][4][4] = '{
    '{'{0,1,2,3}, '{1,3,0,0}, '{2,3,0,0}, '{3,0,0,0}},
    '{'{0,2,0,0}, '{0,1,2,3}, '{2,0,0,0}, '{2,3,0,0}},
    '{'{0,1,0,0}, '{1,0,0,0}, '{0,1,2,3}, '{1,3,0,0}},
    '{'{0,0,0,0}, '{0,1,0,0}, '{0,2,0,0}, '{0,1,2,3}}
  };
  localparam logic [2:0] CELLS_IN [4][4] = '{
    '{4,2,2,1}, '{2,4,1,2}, '{2,1,4,2}, '{1,2,2,4}
  };

  typedef struct packed {
    logic [1:0]                   sel;
    logic [N_QUAD-1:0][CNT_W-1:0] fg;
    logic [N_QUAD-1:0][CNT_W-1:0] bgc;
    logic [N_LANE-1:0]            a_zero;
    logic [N_LANE-1:0]            b_zero;
  } sb_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [NUM_W-1:0] nq;
  } div_step_t;

  // Lanes enumerate the (quadrant, slot) pairs of the chosen configuration in order.
  function automatic logic [1:0] lane_quad(input logic [1:0] sel, input logic [LANE_W-1:0] lane);
    logic [LANE_W-1:0] cnt;
    logic [1:0]        res;
    cnt = '0;
    res = '0;
    for (int q = 0; q < N_QUAD; q++) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < CELLS_IN[sel][q]) begin
          if (cnt == lane) res = 2'(q);
          cnt = cnt + 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic logic [1:0] lane_slot(input logic [1:0] sel, input logic [LANE_W-1:0] lane);
    logic [LANE_W-1:0] cnt;
    logic [1:0]        res;
    cnt = '0;
    res = '0;
    for (int q = 0; q < N_QUAD; q++) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < CELLS_IN[sel][q]) begin
          if (cnt == lane) res = 2'(i);
          cnt = cnt + 1'b1;
        end
      end
    end
    return res;
  endfunction

  // One restoring division step: shift in the next numerator bit, subtract if it fits.
  function automatic div_step_t div_step(input logic [NUM_W-1:0] rem,
                                         input logic [NUM_W-1:0] nq,
                                         input logic [DEN_W-1:0] den);
    div_step_t        res;
    logic [DEN_W-1:0] trial;
    logic [DEN_W-1:0] diff;
    logic             ge;
    trial   = DEN_W'({rem, nq[NUM_W-1]});
    ge      = trial >= den;
    diff    = trial - den;
    res.rem = ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
    res.nq  = {nq[NUM_W-2:0], ge};
    return res;
  endfunction

endpackage
`default_nettype wire

/* rtl/qdr_if.sv */
// Interfaces: input item, result item and configuration write channels.
`default_nettype none
interface qdr_in_if;
  logic                        valid;
  logic                        ready;
  logic [qdr_pkg::COORD_W-1:0] bg_x;
  logic [qdr_pkg::COORD_W-1:0] bg_y;
  logic [qdr_pkg::COORD_W-1:0] cen_x;
  logic [qdr_pkg::COORD_W-1:0] cen_y;
  logic [qdr_pkg::CNT_W-1:0]   fg_q0;
  logic [qdr_pkg::CNT_W-1:0]   fg_q1;
  logic [qdr_pkg::CNT_W-1:0]   fg_q2;
  logic [qdr_pkg::CNT_W-1:0]   fg_q3;
  logic [qdr_pkg::CNT_W-1:0]   bgcnt_q0;
  logic [qdr_pkg::CNT_W-1:0]   bgcnt_q1;
  logic [qdr_pkg::CNT_W-1:0]   bgcnt_q2;
  logic [qdr_pkg::CNT_W-1:0]   bgcnt_q3;
  modport source (output valid, bg_x, bg_y, cen_x, cen_y, fg_q0, fg_q1, fg_q2, fg_q3,
                  bgcnt_q0, bgcnt_q1, bgcnt_q2, bgcnt_q3, input ready);
  modport sink (input valid, bg_x, bg_y, cen_x, cen_y, fg_q0, fg_q1, fg_q2, fg_q3,
                bgcnt_q0, bgcnt_q1, bgcnt_q2, bgcnt_q3, output ready);
endinterface

interface qdr_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [qdr_pkg::OUT_W-1:0] adj_q0;
  logic signed [qdr_pkg::OUT_W-1:0] adj_q1;
  logic signed [qdr_pkg::OUT_W-1:0] adj_q2;
  logic signed [qdr_pkg::OUT_W-1:0] adj_q3;
  modport source (output valid, adj_q0, adj_q1, adj_q2, adj_q3, input ready);
  modport sink (input valid, adj_q0, adj_q1, adj_q2, adj_q3, output ready);
endinterface

interface qdr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [qdr_pkg::CFG_IDX_W-1:0] index;
  logic [qdr_pkg::COORD_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/qdr_geom.sv */
// Front stages: coordinate clamp, strip lengths, strip areas, per-lane numerator and divisor.
`default_nettype none
module qdr_geom #(
  parameter int FRAME_DIM_MAX = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  qdr_in_if.sink                            in_ch,
  input  wire logic [qdr_pkg::COORD_W-1:0]  frame_width,
  input  wire logic [qdr_pkg::COORD_W-1:0]  frame_height,
  output logic                              valid3,
  output logic [qdr_pkg::NUM_W-1:0]         num3 [qdr_pkg::N_LANE],
  output logic [qdr_pkg::DEN_W-1:0]         den3 [qdr_pkg::N_LANE],
  output qdr_pkg::sb_t                      sb3
);

  logic [qdr_pkg::COORD_W-1:0] w, h, bx, by, cx, cy, x0, x1, y0, y1;
  logic [qdr_pkg::COORD_W-1:0] xl [3];
  logic [qdr_pkg::COORD_W-1:0] yl [3];
  logic [qdr_pkg::AREA_W-1:0]  area [qdr_pkg::N_CELL];
  logic [qdr_pkg::NUM_W-1:0]   num_c [qdr_pkg::N_LANE];
  logic [qdr_pkg::DEN_W-1:0]   den_c [qdr_pkg::N_LANE];
  qdr_pkg::sb_t                sb1, sb2, sb1_c;
  logic                        valid1, valid2;

  assign in_ch.ready = en;

  // Stage 1: clamp to the frame, order the centroids, strip lengths
  always_comb begin
    w  = (32'(frame_width) > FRAME_DIM_MAX) ? qdr_pkg::COORD_W'(FRAME_DIM_MAX) : frame_width;
    h  = (32'(frame_height) > FRAME_DIM_MAX) ? qdr_pkg::COORD_W'(FRAME_DIM_MAX) : frame_height;
    bx = (in_ch.bg_x > w) ? w : in_ch.bg_x;
    by = (in_ch.bg_y > h) ? h : in_ch.bg_y;
    cx = (in_ch.cen_x > w) ? w : in_ch.cen_x;
    cy = (in_ch.cen_y > h) ? h : in_ch.cen_y;
    x0 = (cx < bx) ? cx : bx;
    x1 = (cx < bx) ? bx : cx;
    y0 = (cy < by) ? cy : by;
    y1 = (cy < by) ? by : cy;
    sb1_c.sel    = {cy < by, cx < bx};
    sb1_c.fg     = {in_ch.fg_q3, in_ch.fg_q2, in_ch.fg_q1, in_ch.fg_q0};
    sb1_c.bgc    = {in_ch.bgcnt_q3, in_ch.bgcnt_q2, in_ch.bgcnt_q1, in_ch.bgcnt_q0};
    sb1_c.a_zero = '0;
    sb1_c.b_zero = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else if (en) begin
      valid1 <= in_ch.valid;
      valid2 <= valid1;
      valid3 <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xl[0] <= x0;
      xl[1] <= x1 - x0;
      xl[2] <= w - x1;
      yl[0] <= y0;
      yl[1] <= y1 - y0;
      yl[2] <= h - y1;
      sb1   <= sb1_c;
    end
  end

  // Stage 2: cell p = 3*row + col
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          area[r * 3 + k] <= qdr_pkg::AREA_W'(xl[k] * yl[r]);
        end
      end
      sb2 <= sb1;
    end
  end

  // Stage 3: numerator is one target cell, divisor a sum of background cells
  always_comb begin
    for (int k = 0; k < qdr_pkg::N_LANE; k++) begin
      logic [1:0] q, i, f;
      logic [2:0] m;
      q = qdr_pkg::lane_quad(sb2.sel, qdr_pkg::LANE_W'(k));
      i = qdr_pkg::lane_slot(sb2.sel, qdr_pkg::LANE_W'(k));
      f = qdr_pkg::BG_QUAD[sb2.sel][q][i];
      m = qdr_pkg::CELLS_IN[sb2.sel][~q];
      num_c[k] = qdr_pkg::NUM_W'(area[qdr_pkg::CELL_OF[sb2.sel][q][i]]);
      den_c[k] = '0;
      for (int j = 0; j < 4; j++) begin
        if (3'(j) < m) begin
          den_c[k] = den_c[k] + qdr_pkg::DEN_W'(area[qdr_pkg::BG_CELL[sb2.sel][f][j]]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb3.sel <= sb2.sel;
      sb3.fg  <= sb2.fg;
      sb3.bgc <= sb2.bgc;
      for (int k = 0; k < qdr_pkg::N_LANE; k++) begin
        num3[k]         <= num_c[k];
        den3[k]         <= den_c[k];
        sb3.a_zero[k]   <= (num_c[k] == '0);
        sb3.b_zero[k]   <= (den_c[k] == '0);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/qdr_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module qdr_div (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [qdr_pkg::NUM_W-1:0]  num,
  input  wire logic [qdr_pkg::DEN_W-1:0]  den,
  output logic [qdr_pkg::NUM_W-1:0]       quo
);

  localparam int N = qdr_pkg::NUM_W;

  logic [qdr_pkg::NUM_W-1:0] rem_r [N-1];
  logic [qdr_pkg::NUM_W-1:0] nq_r  [N];
  logic [qdr_pkg::DEN_W-1:0] den_r [N-1];
  logic [qdr_pkg::NUM_W-1:0] rem_i [N];
  logic [qdr_pkg::NUM_W-1:0] nq_i  [N];
  logic [qdr_pkg::DEN_W-1:0] den_i [N];
  qdr_pkg::div_step_t        step  [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign rem_i[s] = '0;
      assign nq_i[s]  = num;
      assign den_i[s] = den;
    end else begin : g_next
      assign rem_i[s] = rem_r[s-1];
      assign nq_i[s]  = nq_r[s-1];
      assign den_i[s] = den_r[s-1];
    end

    assign step[s] = qdr_pkg::div_step(rem_i[s], nq_i[s], den_i[s]);

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[s] <= step[s].nq;
      end
    end

    if (s < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= step[s].rem;
          den_r[s] <= den_i[s];
        end
      end
    end
  end

  assign quo = nq_r[N-1];

endmodule
`default_nettype wire

/* rtl/qdr_acc.sv */
// Back stages: ratio fixup and per-quadrant sum, scale by background count, subtract and saturate.
`default_nettype none
module qdr_acc (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       valid_in,
  input  wire logic [qdr_pkg::NUM_W-1:0]  quo [qdr_pkg::N_LANE],
  input  wire qdr_pkg::sb_t               sb,
  qdr_out_if.source                       out_ch
);

  logic [qdr_pkg::NUM_W-1:0]  ratio [qdr_pkg::N_LANE];
  logic [qdr_pkg::RSUM_W-1:0] rsum_c [qdr_pkg::N_QUAD];
  logic [qdr_pkg::RSUM_W-1:0] rsum [qdr_pkg::N_QUAD];
  logic [qdr_pkg::PROD_W-1:0] prod [qdr_pkg::N_QUAD];
  logic [qdr_pkg::N_QUAD-1:0][qdr_pkg::CNT_W-1:0] fg_d, bgc_d, fg_e;
  logic signed [qdr_pkg::DIFF_W-1:0] diff [qdr_pkg::N_QUAD];
  logic signed [qdr_pkg::OUT_W-1:0]  sat [qdr_pkg::N_QUAD];
  logic signed [qdr_pkg::OUT_W-1:0]  adj [qdr_pkg::N_QUAD];
  logic valid_d, valid_e, valid_f;

  always_comb begin
    for (int k = 0; k < qdr_pkg::N_LANE; k++) begin
      if (sb.a_zero[k]) ratio[k] = '0;
      else if (sb.b_zero[k]) ratio[k] = qdr_pkg::ZERO_DIV_RATIO;
      else ratio[k] = quo[k];
    end
    for (int q = 0; q < qdr_pkg::N_QUAD; q++) begin
      rsum_c[q] = '0;
      for (int k = 0; k < qdr_pkg::N_LANE; k++) begin
        if (qdr_pkg::lane_quad(sb.sel, qdr_pkg::LANE_W'(k)) == 2'(q)) begin
          rsum_c[q] = rsum_c[q] + qdr_pkg::RSUM_W'(ratio[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_d <= 1'b0;
      valid_e <= 1'b0;
      valid_f <= 1'b0;
    end else if (en) begin
      valid_d <= valid_in;
      valid_e <= valid_d;
      valid_f <= valid_e;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsum  <= rsum_c;
      fg_d  <= sb.fg;
      bgc_d <= sb.bgc;
      fg_e  <= fg_d;
      for (int q = 0; q < qdr_pkg::N_QUAD; q++) begin
        prod[q] <= qdr_pkg::PROD_W'(rsum[q] * bgc_d[q]);
      end
      adj <= sat;
    end
  end

  always_comb begin
    for (int q = 0; q < qdr_pkg::N_QUAD; q++) begin
      diff[q] = $signed(qdr_pkg::DIFF_W'(fg_e[q])) - $signed(qdr_pkg::DIFF_W'(prod[q]));
      if (diff[q] > $signed(qdr_pkg::DIFF_W'(32'h7fff_ffff))) begin
        sat[q] = 32'sh7fff_ffff;
      end else if (diff[q] < -$signed(qdr_pkg::DIFF_W'(33'h0_8000_0000))) begin
        sat[q] = 32'sh8000_0000;
      end else begin
        sat[q] = diff[q][qdr_pkg::OUT_W-1:0];
      end
    end
  end

  assign out_ch.valid  = valid_f;
  assign out_ch.adj_q0 = adj[0];
  assign out_ch.adj_q1 = adj[1];
  assign out_ch.adj_q2 = adj[2];
  assign out_ch.adj_q3 = adj[3];

endmodule
`default_nettype wire

/* rtl/quadrant_density_redistribution.sv */
// Top level: frame registers, divider lanes, sideband delay line and checks.
// Usage:
//   in_ch  - one transaction carries both centroids and the eight quadrant counts.
//   out_ch - one transaction per input carries adj_q0..adj_q3, saturated signed 32 bit.
//   cfg    - writes frame_width (index 0) or frame_height (index 1); always ready.
//            Write only while no item is in flight.
// Pipeline: 3 geometry stages, 26 divider stages and 3 sum/scale/subtract stages
//   from input transaction to result valid.
// Throughput: one item per cycle while out_ch is not stalled; each of the nine
//   divider lanes is a 26-stage pipeline retiring one quotient bit per stage.
// Stall: the whole pipeline holds while a result sits unaccepted on out_ch;
//   in_ch.ready drops only then, and nothing is lost or repeated.
// Reset (rst, synchronous): clears all valid bits and sets the frame to 640 x 480.
// Frame dimensions above FRAME_DIM_MAX are clamped, coordinates clamp to the frame.
`default_nettype none
module quadrant_density_redistribution #(
  parameter int FRAME_DIM_MAX = 4096
) (
  input  wire logic   clk,
  input  wire logic   rst,
  qdr_in_if.sink      in_ch,
  qdr_out_if.source   out_ch,
  qdr_cfg_if.sink     cfg
);

  localparam int DIV_LAT = qdr_pkg::NUM_W;

  logic                        en;
  logic [qdr_pkg::COORD_W-1:0] frame_width, frame_height;
  logic                        valid3;
  logic [qdr_pkg::NUM_W-1:0]   num3 [qdr_pkg::N_LANE];
  logic [qdr_pkg::DEN_W-1:0]   den3 [qdr_pkg::N_LANE];
  logic [qdr_pkg::NUM_W-1:0]   quo  [qdr_pkg::N_LANE];
  qdr_pkg::sb_t                sb3;
  qdr_pkg::sb_t                sb_d [DIV_LAT];
  logic [DIV_LAT-1:0]          v_d;

  assign en        = !out_ch.valid || out_ch.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= qdr_pkg::FRAME_WIDTH_RST;
      frame_height <= qdr_pkg::FRAME_HEIGHT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        qdr_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg.data;
        qdr_pkg::REG_FRAME_HEIGHT: frame_height <= cfg.data;
        default: ;
      endcase
    end
  end

  qdr_geom #(.FRAME_DIM_MAX(FRAME_DIM_MAX)) u_geom (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_ch        (in_ch),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .valid3       (valid3),
    .num3         (num3),
    .den3         (den3),
    .sb3          (sb3)
  );

  for (genvar k = 0; k < qdr_pkg::N_LANE; k++) begin : g_lane
    qdr_div u_div (
      .clk (clk),
      .en  (en),
      .num (num3[k]),
      .den (den3[k]),
      .quo (quo[k])
    );
  end

  // Sideband rides alongside the divider lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      v_d <= '0;
    end else if (en) begin
      v_d <= {v_d[DIV_LAT-2:0], valid3};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_d[0] <= sb3;
      for (int s = 1; s < DIV_LAT; s++) begin
        sb_d[s] <= sb_d[s-1];
      end
    end
  end

  qdr_acc u_acc (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (v_d[DIV_LAT-1]),
    .quo      (quo),
    .sb       (sb_d[DIV_LAT-1]),
    .out_ch   (out_ch)
  );

`ifndef ASSERT_OFF
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without a blocked result");

  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    (v_d[DIV_LAT-1] && !en) |=> v_d[DIV_LAT-1])
    else $error("item dropped from divider output during stall");
`endif

endmodule
`default_nettype wire
